FILE: hdl/packed_position_decoder_top_macros.svh
// Assertion macros for the packed position decoder.
// Used by packed_position_decoder_top; they expect signals clk and rst_n in scope.
`ifndef PACKED_POSITION_DECODER_TOP_MACROS_SVH
`define PACKED_POSITION_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("packed position decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("packed position decoder: next-cycle check failed");

`endif

FILE: hdl/ppd_pkg.sv
// Shared types, constants and decode tables for the packed position decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package ppd_pkg;

    localparam int RECORD_BITS   = 256;
    localparam int BOARD_SQUARES = 81;
    localparam int BYTE_BITS     = 8;
    localparam int HEADER_BITS   = 15;

    localparam logic [6:0] SQ_LIMIT    = 7'(BOARD_SQUARES);
    localparam logic [6:0] KING_ABSENT = 7'(BOARD_SQUARES);

    // Decode sections.
    localparam logic [1:0] SEC_HEADER = 2'd0;
    localparam logic [1:0] SEC_BOARD  = 2'd1;
    localparam logic [1:0] SEC_HAND   = 2'd2;
    localparam logic [1:0] SEC_DONE   = 2'd3;

    // Field phases within one piece.
    localparam logic [1:0] PH_CODE    = 2'd0;
    localparam logic [1:0] PH_PROMOTE = 2'd1;
    localparam logic [1:0] PH_COLOUR  = 2'd2;

    // Result kinds.
    localparam logic [2:0] KIND_HEADER   = 3'd0;
    localparam logic [2:0] KIND_BOARD    = 3'd1;
    localparam logic [2:0] KIND_HAND     = 3'd2;
    localparam logic [2:0] KIND_PIECEBOX = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // Error codes.
    localparam logic [1:0] ERR_HEADER    = 2'd0;
    localparam logic [1:0] ERR_NO_MATCH  = 2'd1;
    localparam logic [1:0] ERR_OVERRUN   = 2'd2;

    // Piece types.
    localparam logic [2:0] PT_EMPTY = 3'd0;
    localparam logic [2:0] PT_GOLD  = 3'd7;

    localparam logic [3:0] NO_MATCH = 4'd8;

    // Code lengths beyond which no board or hand code can match.
    localparam logic [2:0] BOARD_MAX_LEN = 3'd6;
    localparam logic [2:0] HAND_MAX_LEN  = 3'd5;

    // Prefix codes, read least significant bit first, and their lengths.
    localparam logic [5:0] PIECE_CODE [8] = '{6'h00, 6'h01, 6'h03, 6'h0b,
                                              6'h07, 6'h1f, 6'h3f, 6'h0f};
    localparam logic [2:0] PIECE_LEN  [8] = '{3'd1, 3'd2, 3'd4, 3'd4,
                                              3'd4, 3'd6, 3'd6, 3'd5};

    typedef struct packed {
        logic [2:0] kind;
        logic       side_to_move;
        logic [6:0] black_king_square;
        logic [6:0] white_king_square;
        logic [6:0] square_index;
        logic [2:0] piece_type;
        logic       promoted;
        logic       is_white;
        logic [1:0] error_code;
        logic       end_of_record;
        logic       last_of_byte;
    } result_t;

    typedef struct packed {
        logic load;   // take a new byte
        logic start;  // restart the record with that byte
        logic step;   // decode one bit
        logic err2;   // emit the overrun error
        logic flush;  // release the held result as last of the byte
    } cmd_t;

    typedef struct packed {
        logic halt;        // record finished or in error: no more bits used
        logic step_res;    // the next bit step yields a result
        logic need_err2;   // the next bit step reaches the record end unfinished
        logic stop_after;  // the next bit step ends the record
        logic can_push;    // a new result can be taken into the hold slot
        logic pend_valid;  // a result waits in the hold slot
        logic out_free;    // the output register can be loaded
    } status_t;

    // Advance a square index past the king squares (at most two in a row).
    function automatic logic [6:0] skip_kings(input logic [6:0] s,
                                              input logic [6:0] bk,
                                              input logic [6:0] wk);
        logic [6:0] r;
        r = s;
        if (r < SQ_LIMIT && (r == bk || r == wk))
        begin
            r = r + 7'd1;
        end
        if (r < SQ_LIMIT && (r == bk || r == wk))
        begin
            r = r + 7'd1;
        end
        return r;
    endfunction

    // Match the accumulated code; hand codes drop the leading one bit.
    function automatic logic [3:0] match_code(input logic hand,
                                              input logic [2:0] len,
                                              input logic [5:0] acc);
        logic [3:0] r;
        r = NO_MATCH;
        for (int t = 0; t < 8; t++)
        begin
            if (hand)
            begin
                if (t != 0 && len == PIECE_LEN[t] - 3'd1 && acc == (PIECE_CODE[t] >> 1))
                begin
                    r = 4'(t);
                end
            end
            else if (len == PIECE_LEN[t] && acc == PIECE_CODE[t])
            begin
                r = 4'(t);
            end
        end
        return r;
    endfunction

endpackage

FILE: hdl/ppd_ctrl.sv
// Sequencer for the packed position decoder: byte intake, bit steps, result release.
// Depends on ppd_pkg for the command and status structs.
`timescale 1ns / 1ps
module ppd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_start,
    output logic               in_ready,
    input  ppd_pkg::status_t   status,
    output ppd_pkg::cmd_t      cmd
);
    import ppd_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_BIT   = 2'd1;
    localparam logic [1:0] ST_ERR2  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam logic [2:0] LAST_BIT = 3'(BYTE_BITS - 1);

    logic [1:0] state_reg, state_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    cmd.start    = in_start;
                    bit_cnt_next = 3'd0;
                    state_next   = ST_BIT;
                end
            end
            ST_BIT:
            begin
                if (status.halt)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!status.step_res || status.can_push)
                begin
                    cmd.step = 1'b1;
                    if (status.need_err2)
                    begin
                        state_next = ST_ERR2;
                    end
                    else if (status.stop_after || bit_cnt_reg == LAST_BIT)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                    end
                end
            end
            ST_ERR2:
            begin
                if (status.can_push)
                begin
                    cmd.err2   = 1'b1;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= 3'd0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

FILE: hdl/ppd_datapath.sv
// Decode state, one-bit decode step, result hold slot and output register.
// Depends on ppd_pkg for tables, helper functions and the shared structs.
`timescale 1ns / 1ps
module ppd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  ppd_pkg::cmd_t      cmd,
    output ppd_pkg::status_t   status,
    input  logic [7:0]         byte_in,
    input  logic               out_ready,
    output logic               out_valid,
    output ppd_pkg::result_t   out_result
);
    import ppd_pkg::*;

    logic [7:0]  byte_reg, byte_next;
    logic [8:0]  bitpos_reg, bitpos_next;
    logic [1:0]  section_reg, section_next;
    logic [14:0] hdr_reg, hdr_next;
    logic [5:0]  acc_reg, acc_next;
    logic [2:0]  len_reg, len_next;
    logic [1:0]  phase_reg, phase_next;
    logic [2:0]  dtype_reg, dtype_next;
    logic        prom_reg, prom_next;
    logic [6:0]  sq_reg, sq_next;
    logic [6:0]  bk_reg, bk_next;
    logic [6:0]  wk_reg, wk_next;
    logic        err_reg, err_next;
    logic        pend_valid_reg, pend_valid_next;
    result_t     pend_reg, pend_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    // Values after one bit step.
    logic [1:0]  s_section;
    logic [14:0] s_hdr;
    logic [5:0]  s_acc;
    logic [2:0]  s_len;
    logic [1:0]  s_phase;
    logic [2:0]  s_dtype;
    logic        s_prom;
    logic [6:0]  s_sq;
    logic [6:0]  s_bk;
    logic [6:0]  s_wk;
    logic        s_err;
    logic        s_res_valid;
    result_t     s_res;
    logic        need_err2;

    logic        b;
    logic        hand;
    logic [14:0] hdr_new;
    logic [6:0]  bkv, wkv;
    logic        hbad;
    logic [5:0]  acc_new;
    logic [2:0]  len_new;
    logic [3:0]  t;
    logic [6:0]  sq_first, sq_adv;
    logic        finish, finish_white;
    logic        at_end, end_ok;
    logic        new_valid;
    result_t     new_res;
    result_t     err2_res;
    logic        out_free;

    always_comb
    begin
        b        = byte_reg[0];
        hand     = (section_reg == SEC_HAND);
        hdr_new  = hdr_reg | (15'(b) << bitpos_reg[3:0]);
        bkv      = hdr_new[7:1];
        wkv      = hdr_new[14:8];
        hbad     = bkv > KING_ABSENT || wkv > KING_ABSENT || (bkv < KING_ABSENT && bkv == wkv);
        acc_new  = acc_reg | (6'(b) << len_reg);
        len_new  = len_reg + 3'd1;
        t        = match_code(hand, len_new, acc_new);
        sq_first = skip_kings(7'd0, bkv, wkv);
        sq_adv   = skip_kings(sq_reg + 7'd1, bk_reg, wk_reg);

        s_section    = section_reg;
        s_hdr        = hdr_reg;
        s_acc        = acc_reg;
        s_len        = len_reg;
        s_phase      = phase_reg;
        s_dtype      = dtype_reg;
        s_prom       = prom_reg;
        s_sq         = sq_reg;
        s_bk         = bk_reg;
        s_wk         = wk_reg;
        s_err        = err_reg;
        s_res_valid  = 1'b0;
        s_res        = '0;
        finish       = 1'b0;
        finish_white = 1'b0;
        need_err2    = 1'b0;

        if (section_reg == SEC_HEADER)
        begin
            s_hdr = hdr_new;
            if (bitpos_reg == 9'(HEADER_BITS - 1))
            begin
                s_res_valid = 1'b1;
                if (hbad)
                begin
                    s_res.kind          = KIND_ERROR;
                    s_res.error_code    = ERR_HEADER;
                    s_res.end_of_record = 1'b1;
                    s_err               = 1'b1;
                end
                else
                begin
                    s_bk                    = bkv;
                    s_wk                    = wkv;
                    s_res.kind              = KIND_HEADER;
                    s_res.side_to_move      = hdr_new[0];
                    s_res.black_king_square = bkv;
                    s_res.white_king_square = wkv;
                    s_sq                    = sq_first;
                    s_section = (sq_first >= SQ_LIMIT) ? SEC_HAND : SEC_BOARD;
                    s_acc   = '0;
                    s_len   = '0;
                    s_phase = PH_CODE;
                    s_dtype = PT_EMPTY;
                    s_prom  = 1'b0;
                end
            end
        end
        else
        begin
            case (phase_reg)
                PH_CODE:
                begin
                    s_acc = acc_new;
                    s_len = len_new;
                    if (t != NO_MATCH)
                    begin
                        s_dtype = t[2:0];
                        if (!hand && t[2:0] == PT_EMPTY)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            s_phase = (t[2:0] == PT_GOLD) ? PH_COLOUR : PH_PROMOTE;
                        end
                    end
                    else if (len_new >= (hand ? HAND_MAX_LEN : BOARD_MAX_LEN))
                    begin
                        s_res_valid         = 1'b1;
                        s_res.kind          = KIND_ERROR;
                        s_res.error_code    = ERR_NO_MATCH;
                        s_res.end_of_record = 1'b1;
                        s_err               = 1'b1;
                    end
                end
                PH_PROMOTE:
                begin
                    s_prom  = b;
                    s_phase = PH_COLOUR;
                end
                default:
                begin
                    finish       = 1'b1;
                    finish_white = b;
                end
            endcase

            if (finish)
            begin
                s_res_valid      = 1'b1;
                s_res.piece_type = s_dtype;
                s_res.is_white   = finish_white;
                if (hand)
                begin
                    s_res.kind = s_prom ? KIND_PIECEBOX : KIND_HAND;
                end
                else
                begin
                    s_res.kind         = KIND_BOARD;
                    s_res.square_index = sq_reg;
                    s_res.promoted     = s_prom;
                    s_sq               = sq_adv;
                    if (sq_adv >= SQ_LIMIT)
                    begin
                        s_section = SEC_HAND;
                    end
                end
                s_acc   = '0;
                s_len   = '0;
                s_phase = PH_CODE;
                s_dtype = PT_EMPTY;
                s_prom  = 1'b0;
            end
        end

        // The record end: clean only between hand items.
        at_end = (bitpos_reg == 9'(RECORD_BITS - 1));
        end_ok = (s_section == SEC_HAND && s_phase == PH_CODE && s_len == 3'd0);
        if (at_end && !s_err)
        begin
            if (end_ok)
            begin
                s_section           = SEC_DONE;
                s_res.end_of_record = 1'b1;
            end
            else
            begin
                need_err2 = 1'b1;
            end
        end
    end

    always_comb
    begin
        err2_res               = '0;
        err2_res.kind          = KIND_ERROR;
        err2_res.error_code    = ERR_OVERRUN;
        err2_res.end_of_record = 1'b1;
        new_valid = (cmd.step && s_res_valid) || cmd.err2;
        new_res   = cmd.err2 ? err2_res : s_res;
        out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        byte_next    = byte_reg;
        bitpos_next  = bitpos_reg;
        section_next = section_reg;
        hdr_next     = hdr_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        phase_next   = phase_reg;
        dtype_next   = dtype_reg;
        prom_next    = prom_reg;
        sq_next      = sq_reg;
        bk_next      = bk_reg;
        wk_next      = wk_reg;
        err_next     = err_reg;

        if (cmd.load)
        begin
            byte_next = byte_in;
            if (cmd.start)
            begin
                bitpos_next  = '0;
                section_next = SEC_HEADER;
                hdr_next     = '0;
                acc_next     = '0;
                len_next     = '0;
                phase_next   = PH_CODE;
                dtype_next   = PT_EMPTY;
                prom_next    = 1'b0;
                sq_next      = '0;
                bk_next      = KING_ABSENT;
                wk_next      = KING_ABSENT;
                err_next     = 1'b0;
            end
        end
        if (cmd.step)
        begin
            byte_next    = byte_reg >> 1;
            bitpos_next  = bitpos_reg + 9'd1;
            section_next = s_section;
            hdr_next     = s_hdr;
            acc_next     = s_acc;
            len_next     = s_len;
            phase_next   = s_phase;
            dtype_next   = s_dtype;
            prom_next    = s_prom;
            sq_next      = s_sq;
            bk_next      = s_bk;
            wk_next      = s_wk;
            err_next     = s_err;
        end
        if (cmd.err2)
        begin
            err_next = 1'b1;
        end
    end

    // A new result displaces the held one, which is then known not to be last.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        if (new_valid)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_valid_next = 1'b1;
            pend_next       = new_res;
        end
        if (cmd.flush)
        begin
            out_valid_next        = 1'b1;
            out_next              = pend_reg;
            out_next.last_of_byte = 1'b1;
            pend_valid_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitpos_reg     <= '0;
            section_reg    <= SEC_HEADER;
            hdr_reg        <= '0;
            acc_reg        <= '0;
            len_reg        <= '0;
            phase_reg      <= PH_CODE;
            dtype_reg      <= PT_EMPTY;
            prom_reg       <= 1'b0;
            sq_reg         <= '0;
            bk_reg         <= KING_ABSENT;
            wk_reg         <= KING_ABSENT;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            bitpos_reg     <= bitpos_next;
            section_reg    <= section_next;
            hdr_reg        <= hdr_next;
            acc_reg        <= acc_next;
            len_reg        <= len_next;
            phase_reg      <= phase_next;
            dtype_reg      <= dtype_next;
            prom_reg       <= prom_next;
            sq_reg         <= sq_next;
            bk_reg         <= bk_next;
            wk_reg         <= wk_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    always_comb
    begin
        status.halt       = err_reg || section_reg == SEC_DONE;
        status.step_res   = s_res_valid;
        status.need_err2  = need_err2;
        status.stop_after = s_err || s_section == SEC_DONE;
        status.can_push   = !pend_valid_reg || out_free;
        status.pend_valid = pend_valid_reg;
        status.out_free   = out_free;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

endmodule

FILE: hdl/packed_position_decoder_top.sv
// Top level of the packed position decoder: stream ports, field packing, assertions.
// Depends on ppd_pkg, ppd_ctrl, ppd_datapath and the assertion macro header.
//
//   Channel   | Direction | Carries
//   ----------+-----------+--------------------------------------------------
//   s_*       | in        | one byte of a 256-bit packed position per request
//   m_*       | out       | one decoded header, square, hand piece or error
//
// A byte passes through intake, a decode step for each bit (up to eight; a byte
// that arrives after the record has ended or failed decodes none), an overrun
// error where one is due and the release of its last result; only then is the
// next byte taken. Each result waits in a one-entry hold slot until the next
// result or the end of its byte releases it; a bit step that yields a result
// stalls only while that slot is full and the output register is full and stalled.
`timescale 1ns / 1ps
`include "packed_position_decoder_top_macros.svh"
module packed_position_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] record_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [0] side_to_move, [7:1] black_king_square,
                                   // [14:8] white_king_square, [21:15] square_index,
                                   // [24:22] piece_type, [25] promoted, [26] is_white,
                                   // [28:27] error_code, [29] last_of_byte, [31:30] zero
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // end_of_record
);
    import ppd_pkg::*;

    cmd_t    cmd;
    status_t status;
    result_t result;

    // The controller sequences intake, up to eight bit steps per byte and the release
    // of the held result; the datapath owns all decode state. rst_n clears
    // all decode state to the start of a record, and a request with s_tuser
    // high restarts decoding at that byte.
    ppd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_start (s_tuser),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ppd_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .byte_in    (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (result)
    );

    // Pack the result fields, lowest field in the lowest bits.
    assign m_tdata = {2'b00,
                      result.last_of_byte,
                      result.error_code,
                      result.is_white,
                      result.promoted,
                      result.piece_type,
                      result.square_index,
                      result.white_king_square,
                      result.black_king_square,
                      result.side_to_move};
    assign m_tuser = result.kind;
    assign m_tlast = result.end_of_record;

    // Every error closes the record.
    `PPD_ASSERT_IMPLY(a_error_ends_record, m_tvalid && m_tuser == KIND_ERROR, m_tlast)
    // A record always ends on the final result of its byte.
    `PPD_ASSERT_IMPLY(a_end_is_last_of_byte, m_tvalid && m_tlast, m_tdata[29])
    // A new byte is only taken once the previous byte's results have left the hold slot.
    `PPD_ASSERT_IMPLY(a_intake_slot_empty, s_tready, !status.pend_valid)
    // One byte at a time: intake closes after each request.
    `PPD_ASSERT_NEXT(a_single_byte, s_tvalid && s_tready, !s_tready)

endmodule

FILE: verif/position_check_pkg.sv
// Scoreboard for the packed position decoder testbench: a bit-serial decoder
// of its own that predicts every result, and the in-order result checker.
// Depends on ppd_pkg for the result type, the decode codes and the piece code tables.
`timescale 1ns / 1ps
package position_check_pkg;
    import ppd_pkg::*;

    class position_scoreboard;
        // Decoder state, kept in step with the block.
        logic [8:0]  bit_pos;
        logic [1:0]  section;
        logic [14:0] header_bits;
        logic [5:0]  code_acc;
        logic [2:0]  code_len;
        logic [1:0]  phase;
        logic [2:0]  piece;
        logic        promote;
        logic [6:0]  square;
        logic [6:0]  king_of_black;
        logic [6:0]  king_of_white;
        logic        halted;

        result_t     byte_results[$];
        result_t     awaited[$];
        int unsigned kind_tally[5];
        int unsigned checked;
        int unsigned failures;

        function new();
            restart();
            checked  = 0;
            failures = 0;
            foreach (kind_tally[k])
            begin
                kind_tally[k] = 0;
            end
        endfunction

        function void clear_piece();
            code_acc = '0;
            code_len = '0;
            phase    = PH_CODE;
            piece    = PT_EMPTY;
            promote  = 1'b0;
        endfunction

        function void restart();
            bit_pos       = '0;
            section       = SEC_HEADER;
            header_bits   = '0;
            clear_piece();
            square        = '0;
            king_of_black = KING_ABSENT;
            king_of_white = KING_ABSENT;
            halted        = 1'b0;
        endfunction

        function void emit(result_t r);
            byte_results.push_back(r);
            kind_tally[r.kind]++;
        endfunction

        function void raise_error(logic [1:0] code);
            result_t r;
            r = '0;
            r.kind          = KIND_ERROR;
            r.error_code    = code;
            r.end_of_record = 1'b1;
            emit(r);
            halted = 1'b1;
        endfunction

        function logic [6:0] next_square(logic [6:0] s);
            while (s < SQ_LIMIT && (s == king_of_black || s == king_of_white))
            begin
                s = s + 7'd1;
            end
            return s;
        endfunction

        // Returns the piece type whose code matches the bits so far, or -1.
        function int lookup_code(bit hand);
            logic [2:0] want_len;
            logic [5:0] want_code;
            for (int t = (hand ? 1 : 0); t < 8; t++)
            begin
                want_len  = hand ? PIECE_LEN[t] - 3'd1 : PIECE_LEN[t];
                want_code = hand ? PIECE_CODE[t] >> 1 : PIECE_CODE[t];
                if (code_len == want_len && code_acc == want_code)
                begin
                    return t;
                end
            end
            return -1;
        endfunction

        function void finish_piece(logic white);
            result_t r;
            r = '0;
            r.piece_type = piece;
            r.is_white   = white;
            if (section == SEC_BOARD)
            begin
                r.kind         = KIND_BOARD;
                r.square_index = square;
                r.promoted     = promote;
                emit(r);
                square = next_square(square + 7'd1);
                if (square >= SQ_LIMIT)
                begin
                    section = SEC_HAND;
                end
            end
            else
            begin
                r.kind = promote ? KIND_PIECEBOX : KIND_HAND;
                emit(r);
            end
            clear_piece();
        endfunction

        function void take_piece_bit(logic b);
            bit hand;
            int t;
            hand = (section == SEC_HAND);
            if (phase == PH_CODE)
            begin
                if (code_len < 3'd6)
                begin
                    code_acc[code_len] = b;
                end
                code_len = code_len + 3'd1;
                t = lookup_code(hand);
                if (t >= 0)
                begin
                    piece = 3'(t);
                    if (!hand && piece == PT_EMPTY)
                    begin
                        finish_piece(1'b0);
                    end
                    else
                    begin
                        phase = (piece == PT_GOLD) ? PH_COLOUR : PH_PROMOTE;
                    end
                end
                else if (code_len >= (hand ? HAND_MAX_LEN : BOARD_MAX_LEN))
                begin
                    raise_error(ERR_NO_MATCH);
                end
            end
            else if (phase == PH_PROMOTE)
            begin
                promote = b;
                phase   = PH_COLOUR;
            end
            else
            begin
                finish_piece(b);
            end
        endfunction

        function void close_header();
            logic [6:0] bk;
            logic [6:0] wk;
            result_t    r;
            bk = header_bits[7:1];
            wk = header_bits[14:8];
            if (bk > KING_ABSENT || wk > KING_ABSENT || (bk < KING_ABSENT && bk == wk))
            begin
                raise_error(ERR_HEADER);
                return;
            end
            king_of_black = bk;
            king_of_white = wk;
            r = '0;
            r.kind              = KIND_HEADER;
            r.side_to_move      = header_bits[0];
            r.black_king_square = bk;
            r.white_king_square = wk;
            emit(r);
            square  = next_square(7'd0);
            section = (square >= SQ_LIMIT) ? SEC_HAND : SEC_BOARD;
            clear_piece();
        endfunction

        // Decodes one accepted byte and queues the results it should cause.
        function void decode_byte(logic [7:0] data, logic start);
            int      prior;
            result_t r;
            if (start)
            begin
                restart();
            end
            byte_results.delete();
            for (int i = 0; i < 8; i++)
            begin
                if (halted || section == SEC_DONE || bit_pos >= 9'(RECORD_BITS))
                begin
                    break;
                end
                prior = byte_results.size();
                if (section == SEC_HEADER)
                begin
                    header_bits[bit_pos[3:0]] = data[i];
                    if (bit_pos == 9'(HEADER_BITS - 1))
                    begin
                        close_header();
                    end
                end
                else
                begin
                    take_piece_bit(data[i]);
                end
                bit_pos = bit_pos + 9'd1;
                if (halted)
                begin
                    break;
                end
                if (bit_pos >= 9'(RECORD_BITS))
                begin
                    if (section == SEC_HAND && phase == PH_CODE && code_len == 3'd0)
                    begin
                        if (byte_results.size() > prior)
                        begin
                            r = byte_results[byte_results.size() - 1];
                            r.end_of_record = 1'b1;
                            byte_results[byte_results.size() - 1] = r;
                        end
                        section = SEC_DONE;
                    end
                    else
                    begin
                        raise_error(ERR_OVERRUN);
                    end
                    break;
                end
            end
            if (byte_results.size() > 0)
            begin
                r = byte_results[byte_results.size() - 1];
                r.last_of_byte = 1'b1;
                byte_results[byte_results.size() - 1] = r;
            end
            foreach (byte_results[k])
            begin
                awaited.push_back(byte_results[k]);
            end
        endfunction

        function bit same(string name, logic [6:0] want, logic [6:0] seen);
            if (want !== seen)
            begin
                $display("%0t ns: result %0d field %s expected %0d, actual %0d",
                         $time, checked, name, want, seen);
            end
            return want === seen;
        endfunction

        function void check_result(result_t got);
            result_t want;
            bit      ok;
            checked++;
            if (awaited.size() == 0)
            begin
                failures++;
                $display("%0t ns: result %0d expected none, actual kind %0d",
                         $time, checked, got.kind);
                return;
            end
            want = awaited.pop_front();
            ok = 1'b1;
            ok &= same("kind", 7'(want.kind), 7'(got.kind));
            ok &= same("side_to_move", 7'(want.side_to_move), 7'(got.side_to_move));
            ok &= same("black_king_square", want.black_king_square, got.black_king_square);
            ok &= same("white_king_square", want.white_king_square, got.white_king_square);
            ok &= same("square_index", want.square_index, got.square_index);
            ok &= same("piece_type", 7'(want.piece_type), 7'(got.piece_type));
            ok &= same("promoted", 7'(want.promoted), 7'(got.promoted));
            ok &= same("is_white", 7'(want.is_white), 7'(got.is_white));
            ok &= same("error_code", 7'(want.error_code), 7'(got.error_code));
            ok &= same("end_of_record", 7'(want.end_of_record), 7'(got.end_of_record));
            ok &= same("last_of_byte", 7'(want.last_of_byte), 7'(got.last_of_byte));
            if (!ok)
            begin
                failures++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

endpackage

FILE: verif/testbench.sv
// Top-level testbench for packed_position_decoder_top: builds packed positions,
// streams them in byte by byte and checks every decoded result in order.
// Depends on ppd_pkg, position_check_pkg and the decoder RTL.
`timescale 1ns / 1ps
module testbench;
    import ppd_pkg::*;
    import position_check_pkg::*;

    // Number of random requests aimed for after the directed part.
    localparam int unsigned ITEM_TARGET = 240;

    // Piece types used when composing records by hand.
    localparam logic [2:0] PT_PAWN   = 3'd1;
    localparam logic [2:0] PT_LANCE  = 3'd2;
    localparam logic [2:0] PT_KNIGHT = 3'd3;
    localparam logic [2:0] PT_SILVER = 3'd4;
    localparam logic [2:0] PT_BISHOP = 3'd5;
    localparam logic [2:0] PT_ROOK   = 3'd6;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    position_scoreboard score = new();

    // Pacing of the two sides, in percent of cycles spent idle or stalled.
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    int unsigned bytes_sent;
    int unsigned counted_items;
    int unsigned records_sent;

    // The record being composed, least significant bit first, and its fill level.
    logic [255:0] rec;
    int unsigned  rec_fill;

    packed_position_decoder_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Appends the low bits of a value to the record, lowest bit first.
    task automatic push_field(input logic [7:0] value, input int unsigned width);
        for (int i = 0; i < width; i++)
        begin
            if (rec_fill < RECORD_BITS)
            begin
                rec[rec_fill] = value[i];
            end
            rec_fill++;
        end
    endtask

    // Starts a fresh record with the 15-bit header: side, black king, white king.
    task automatic compose_header(input logic side, input logic [6:0] bk,
                                  input logic [6:0] wk);
        rec      = '0;
        rec_fill = 0;
        push_field(8'(side), 1);
        push_field(8'(bk), 7);
        push_field(8'(wk), 7);
    endtask

    // Bits a board item takes: the code, a promote bit except for gold, a colour bit;
    // an empty square is its one-bit code alone.
    function automatic int unsigned board_cost(input int t);
        if (t == 0)
        begin
            return 1;
        end
        return int'(PIECE_LEN[t]) + ((t == int'(PT_GOLD)) ? 1 : 2);
    endfunction

    // Hand items drop the leading one bit of the board code.
    function automatic int unsigned hand_cost(input int t);
        return int'(PIECE_LEN[t]) - 1 + ((t == int'(PT_GOLD)) ? 1 : 2);
    endfunction

    task automatic push_board_piece(input int t, input logic prom, input logic white);
        push_field(8'(PIECE_CODE[t]), int'(PIECE_LEN[t]));
        if (t != 0)
        begin
            if (t != int'(PT_GOLD))
            begin
                push_field(8'(prom), 1);
            end
            push_field(8'(white), 1);
        end
    endtask

    task automatic push_hand_piece(input int t, input logic prom, input logic white);
        push_field(8'(PIECE_CODE[t] >> 1), int'(PIECE_LEN[t]) - 1);
        if (t != int'(PT_GOLD))
        begin
            push_field(8'(prom), 1);
        end
        push_field(8'(white), 1);
    endtask

    // Two legal king squares: mostly distinct board squares, now and then
    // one or both kings absent.
    task automatic pick_kings(output logic [6:0] bk, output logic [6:0] wk);
        int unsigned mode;
        mode = $urandom_range(9);
        bk = 7'($urandom_range(80));
        wk = 7'($urandom_range(80));
        while (wk == bk)
        begin
            wk = 7'($urandom_range(80));
        end
        if (mode == 0)
        begin
            bk = KING_ABSENT;
        end
        else if (mode == 1)
        begin
            wk = KING_ABSENT;
        end
        else if (mode == 2)
        begin
            bk = KING_ABSENT;
            wk = KING_ABSENT;
        end
    endtask

    // Composes a well-formed position that ends exactly at the record end.
    // Board pieces are placed only while the rest of the board still fits;
    // the hand then fills the remaining bits, which cannot be 1, 2 or 4 since
    // no mix of 3-, 5- and 7-bit hand items adds up to those.
    task automatic compose_position();
        logic [6:0]  bk;
        logic [6:0]  wk;
        int unsigned squares_after;
        int unsigned occupancy;
        int unsigned room;
        int unsigned cost;
        int          t;
        do
        begin
            pick_kings(bk, wk);
            compose_header(1'($urandom_range(1)), bk, wk);
            squares_after = BOARD_SQUARES - ((bk < KING_ABSENT) ? 1 : 0)
                                          - ((wk < KING_ABSENT) ? 1 : 0);
            occupancy = $urandom_range(10, 55);
            for (int s = 0; s < BOARD_SQUARES; s++)
            begin
                if (s == int'(bk) || s == int'(wk))
                begin
                    continue;
                end
                squares_after--;
                t = $urandom_range(1, 7);
                if ($urandom_range(99) < occupancy
                    && rec_fill + board_cost(t) + squares_after <= RECORD_BITS)
                begin
                    push_board_piece(t, 1'($urandom_range(3) == 0), 1'($urandom_range(1)));
                end
                else
                begin
                    push_board_piece(0, 1'b0, 1'b0);
                end
            end
            room = RECORD_BITS - rec_fill;
        end
        while (room == 1 || room == 2 || room == 4);
        while (rec_fill < RECORD_BITS)
        begin
            t    = $urandom_range(1, 7);
            room = RECORD_BITS - rec_fill;
            cost = hand_cost(t);
            if (cost <= room && room - cost != 1 && room - cost != 2 && room - cost != 4)
            begin
                push_hand_piece(t, 1'($urandom_range(7) == 0), 1'($urandom_range(1)));
            end
        end
    endtask

    // Offers one request, idling first as the sender pacing asks, and returns
    // at the falling edge after the request was accepted. Ignored trailing
    // bytes are sent with counts low so that they do not add to the item total.
    task automatic send_byte(input logic [7:0] data, input logic start, input bit counts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= start;
        do
        begin
            @(posedge clk);
        end
        while (!(s_tvalid && s_tready));
        score.decode_byte(data, start);
        bytes_sent++;
        if (counts)
        begin
            counted_items++;
        end
        @(negedge clk);
    endtask

    // Sends the first bytes of the composed record; only the first may carry
    // the restart flag.
    task automatic send_record(input int unsigned nbytes, input logic first_start);
        for (int i = 0; i < nbytes; i++)
        begin
            send_byte(rec[8 * i +: 8], (i == 0) ? first_start : 1'b0, 1'b1);
        end
        records_sent++;
    endtask

    // The receiver stalls at random; its ready changes only at the falling edge.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Every result taken at a rising edge is unpacked and handed to the scoreboard.
    always @(posedge clk)
    begin
        result_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind              = m_tuser;
            seen.side_to_move      = m_tdata[0];
            seen.black_king_square = m_tdata[7:1];
            seen.white_king_square = m_tdata[14:8];
            seen.square_index      = m_tdata[21:15];
            seen.piece_type        = m_tdata[24:22];
            seen.promoted          = m_tdata[25];
            seen.is_white          = m_tdata[26];
            seen.error_code        = m_tdata[28:27];
            seen.last_of_byte      = m_tdata[29];
            seen.end_of_record     = m_tlast;
            score.check_result(seen);
        end
    end

    // Main stimulus: a short directed part, then random records under four
    // pacing phases, then a drain of every outstanding result.
    initial
    begin
        int unsigned directed_items;
        int unsigned phase;
        int unsigned pick;
        logic [6:0]  bk;
        logic [6:0]  wk;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        bytes_sent    = 0;
        counted_items = 0;
        records_sent  = 0;
        rec           = '0;
        rec_fill      = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // No restart flag on the very first request: the reset state must
        // already be the start of a record. Kings on the first and last
        // squares, then empties, a promoted white rook, a black gold, a bishop.
        compose_header(1'b1, 7'd0, 7'd80);
        push_field(8'h00, 8);
        push_field(8'h00, 1);
        push_board_piece(PT_ROOK, 1'b1, 1'b1);
        push_board_piece(PT_GOLD, 1'b0, 1'b0);
        push_board_piece(PT_BISHOP, 1'b0, 1'b1);
        send_record(6, 1'b0);

        // Bad headers: a black king beyond the board, then a following byte
        // that must be ignored; a white king at the top of its range; both
        // kings on the same square.
        compose_header(1'b0, 7'd82, 7'd5);
        send_record(2, 1'b1);
        send_byte(8'hff, 1'b0, 1'b0);
        compose_header(1'b1, KING_ABSENT, 7'd127);
        send_record(2, 1'b1);
        compose_header(1'b0, 7'd40, 7'd40);
        send_record(2, 1'b1);

        // Both kings absent, so decoding starts at square 0.
        compose_header(1'b0, KING_ABSENT, KING_ABSENT);
        push_board_piece(PT_PAWN, 1'b1, 1'b0);
        push_board_piece(PT_LANCE, 1'b0, 1'b1);
        push_board_piece(PT_KNIGHT, 1'b1, 1'b1);
        push_board_piece(PT_SILVER, 1'b0, 1'b0);
        send_record(4, 1'b1);

        // Kings on two neighbouring squares at the end of the board.
        compose_header(1'b1, 7'd80, 7'd79);
        send_record(3, 1'b1);
        directed_items = counted_items;

        while (counted_items < directed_items + ITEM_TARGET)
        begin
            phase = (counted_items - directed_items) * 4 / ITEM_TARGET;
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 86;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 86;
                end
                default:
                begin
                    send_idle_pct = 20;
                    stall_pct     = 20;
                end
            endcase
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                // A clean position; sometimes followed by bytes that the
                // finished record must ignore.
                compose_position();
                send_record(32, 1'b1);
                if ($urandom_range(3) == 0)
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                    end
                end
            end
            else if (pick < 75)
            begin
                // A clean position with a few flipped bits past the header,
                // which shifts decoding and often runs over the record end.
                compose_position();
                repeat ($urandom_range(1, 3))
                begin
                    rec_fill = $urandom_range(HEADER_BITS, RECORD_BITS - 1);
                    rec[rec_fill] = ~rec[rec_fill];
                end
                send_record(32, 1'b1);
            end
            else if (pick < 83)
            begin
                // A legal header followed by noise.
                pick_kings(bk, wk);
                compose_header(1'($urandom_range(1)), bk, wk);
                for (int i = HEADER_BITS; i < RECORD_BITS; i++)
                begin
                    rec[i] = 1'($urandom_range(1));
                end
                send_record(32, 1'b1);
            end
            else if (pick < 91)
            begin
                // A broken header; any bytes after it are ignored.
                bk = 7'($urandom_range(127));
                wk = 7'($urandom_range(127));
                case ($urandom_range(2))
                    0:       bk = 7'($urandom_range(82, 127));
                    1:       wk = 7'($urandom_range(82, 127));
                    default: wk = 7'($urandom_range(80));
                endcase
                if (bk <= KING_ABSENT && wk <= KING_ABSENT)
                begin
                    bk = wk;
                end
                compose_header(1'($urandom_range(1)), bk, wk);
                for (int i = HEADER_BITS; i < 32; i++)
                begin
                    rec[i] = 1'($urandom_range(1));
                end
                send_record(2, 1'b1);
                repeat ($urandom_range(2))
                begin
                    send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
                end
            end
            else
            begin
                // A record cut short by the restart of the next one.
                compose_position();
                send_record($urandom_range(1, 31), 1'b1);
            end
        end

        s_tvalid      <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        while (score.pending() != 0)
        begin
            @(posedge clk);
        end
        // Run on past the drain so that any stray result beyond the last expected
        // one is seen.
        repeat (40) @(posedge clk);

        $display("Sent %0d records in %0d requests with no idling, a slow sender,",
                 records_sent, bytes_sent);
        $display("a stalling receiver and both; %0d results checked:", score.checked);
        $display("%0d headers, %0d squares, %0d hand, %0d piece-box, %0d errors.",
                 score.kind_tally[KIND_HEADER], score.kind_tally[KIND_BOARD],
                 score.kind_tally[KIND_HAND], score.kind_tally[KIND_PIECEBOX],
                 score.kind_tally[KIND_ERROR]);
        if (score.failures == 0 && score.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run under the heaviest pacing.
    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ppd_pkg.sv
hdl/ppd_ctrl.sv
hdl/ppd_datapath.sv
hdl/packed_position_decoder_top.sv
verif/position_check_pkg.sv
verif/testbench.sv
